/* sv/mpa_pkg.sv */
// Shared types, constants and helper functions of the max pooling block.
package mpa_pkg;

   localparam int VALUE_W    = 16;
   localparam int COORD_W    = 8;
   localparam int IDX_W      = 16;
   localparam int DIM_W      = 9;
   localparam int POOL_W     = 4;
   localparam int OFS_W      = 3;
   localparam int CSR_DATA_W = 9;
   localparam int MAX_MAP_COLS = 256;
   localparam int ADDR_W     = $clog2(MAX_MAP_COLS);
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

   localparam logic [POOL_W-1:0] POOL_MAX    = 4'd8;
   localparam logic [DIM_W-1:0]  DIM_MAX     = 9'd256;
   localparam logic [1:0]        SETTLE_CYCLES = 2'd3;

   typedef enum logic [1:0] {
      CSR_POOL_HEIGHT,
      CSR_POOL_WIDTH,
      CSR_MAP_ROWS,
      CSR_MAP_COLS
   } csr_index_type;

   // Clamped registers plus values derived from them.
   typedef struct packed {
      logic [POOL_W-1:0] ph;
      logic [POOL_W-1:0] pw;
      logic [DIM_W-1:0]  rows;
      logic [DIM_W-1:0]  cols;
      logic [DIM_W-1:0]  pc;
      logic [DIM_W-1:0]  pr_m1;
      logic [DIM_W-1:0]  pc_m1;
      logic [DIM_W-1:0]  row_lim;
      logic [DIM_W-1:0]  col_lim;
   } cfg_type;

   // Position of the pixel about to be accepted and what it means.
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] wr;
      logic [COORD_W-1:0] wc;
      logic               in_window;
      logic               first;
      logic               emit;
      logic               map_last;
   } pos_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [VALUE_W-1:0] value;
      logic               last;
   } result_type;

   function automatic logic [POOL_W-1:0] clamp_pool(input logic [POOL_W-1:0] v);
      logic [POOL_W-1:0] r;
      r = v;
      if (v == '0) r = 4'd1;
      else if (v > POOL_MAX) r = POOL_MAX;
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = 9'd1;
      else if (v > DIM_MAX) r = DIM_MAX;
      return r;
   endfunction

   // Quotient of a value below 512 by a divisor of 1 to 8: shifts or a
   // reciprocal multiply that is exact over the whole input range.
   function automatic logic [DIM_W-1:0] div_small(input logic [DIM_W-1:0] x,
                                                  input logic [POOL_W-1:0] d);
      logic [19:0] p;
      logic [19:0] q;
      p = '0;
      case (d)
         4'd1:    q = 20'(x);
         4'd2:    q = 20'(x) >> 1;
         4'd3:    begin p = 20'(x) * 20'd171; q = p >> 9; end
         4'd4:    q = 20'(x) >> 2;
         4'd5:    begin p = 20'(x) * 20'd205; q = p >> 10; end
         4'd6:    begin p = 20'(x) * 20'd171; q = p >> 10; end
         4'd7:    begin p = 20'(x) * 20'd293; q = p >> 11; end
         4'd8:    q = 20'(x) >> 3;
         default: q = 20'(x);
      endcase
      return q[DIM_W-1:0];
   endfunction

endpackage

/* sv/mpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/mpa_cfg.sv */
// Configuration registers, derived window geometry and settle timer.
module mpa_cfg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_addr,
   input  logic [mpa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output mpa_pkg::cfg_type               cfg,
   output logic                           settled
);
   import mpa_pkg::*;

   logic [POOL_W-1:0] ph_ff, pw_ff;
   logic [DIM_W-1:0]  rows_ff, cols_ff;
   logic [DIM_W-1:0]  pr_ff, pc_ff, pr_m1_ff, pc_m1_ff, row_lim_ff, col_lim_ff;
   logic [1:0]        settle_ff, settle_in;
   logic [12:0]       row_prod, col_prod;

   always_comb begin
      if (csr_we) settle_in = SETTLE_CYCLES;
      else if (settle_ff != 2'd0) settle_in = settle_ff - 2'd1;
      else settle_in = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff     <= 4'd2;
         pw_ff     <= 4'd2;
         rows_ff   <= DIM_MAX;
         cols_ff   <= DIM_MAX;
         settle_ff <= SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_addr))
               CSR_POOL_HEIGHT: ph_ff   <= clamp_pool(csr_wdata[POOL_W-1:0]);
               CSR_POOL_WIDTH:  pw_ff   <= clamp_pool(csr_wdata[POOL_W-1:0]);
               CSR_MAP_ROWS:    rows_ff <= clamp_dim(csr_wdata);
               CSR_MAP_COLS:    cols_ff <= clamp_dim(csr_wdata);
               default:         ;
            endcase
         end
      end
   end

   assign row_prod = 13'(pr_ff) * 13'(ph_ff);
   assign col_prod = 13'(pc_ff) * 13'(pw_ff);

   // Two register steps: window counts, then limits of the whole windows.
   always_ff @(posedge clock) begin
      pr_ff      <= div_small(rows_ff, ph_ff);
      pc_ff      <= div_small(cols_ff, pw_ff);
      pr_m1_ff   <= pr_ff - 9'd1;
      pc_m1_ff   <= pc_ff - 9'd1;
      row_lim_ff <= row_prod[DIM_W-1:0];
      col_lim_ff <= col_prod[DIM_W-1:0];
   end

   always_comb begin
      cfg.ph      = ph_ff;
      cfg.pw      = pw_ff;
      cfg.rows    = rows_ff;
      cfg.cols    = cols_ff;
      cfg.pc      = pc_ff;
      cfg.pr_m1   = pr_m1_ff;
      cfg.pc_m1   = pc_m1_ff;
      cfg.row_lim = row_lim_ff;
      cfg.col_lim = col_lim_ff;
   end

   assign settled = (settle_ff == 2'd0);

endmodule

/* sv/mpa_pos.sv */
// Pixel position counters with window offsets and window indexes.
module mpa_pos (
   input  logic             clock,
   input  logic             reset,
   input  mpa_pkg::cfg_type cfg,
   input  logic             recalc,
   input  logic             advance,
   output mpa_pkg::pos_type pos
);
   import mpa_pkg::*;

   logic [COORD_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [COORD_W-1:0] wr_ff, wr_in, wc_ff, wc_in;
   logic [OFS_W-1:0]   ro_ff, ro_in, co_ff, co_in;
   logic [DIM_W-1:0]   row_div, col_div, row_next, col_next;
   logic [11:0]        row_base, col_base, row_rem, col_rem;
   logic               ro_end, co_end;

   assign row_div  = div_small({1'b0, row_ff}, cfg.ph);
   assign col_div  = div_small({1'b0, col_ff}, cfg.pw);
   assign row_base = 12'(wr_ff) * 12'(cfg.ph);
   assign col_base = 12'(wc_ff) * 12'(cfg.pw);
   assign row_rem  = 12'(row_ff) - row_base;
   assign col_rem  = 12'(col_ff) - col_base;
   assign row_next = {1'b0, row_ff} + 9'd1;
   assign col_next = {1'b0, col_ff} + 9'd1;
   assign ro_end   = ({1'b0, ro_ff} == cfg.ph - 4'd1);
   assign co_end   = ({1'b0, co_ff} == cfg.pw - 4'd1);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      wr_in  = wr_ff;
      wc_in  = wc_ff;
      ro_in  = ro_ff;
      co_in  = co_ff;
      if (recalc) begin
         // rebuild quotients, then remainders, from the raw position
         wr_in = row_div[COORD_W-1:0];
         wc_in = col_div[COORD_W-1:0];
         ro_in = row_rem[OFS_W-1:0];
         co_in = col_rem[OFS_W-1:0];
      end else if (advance) begin
         if (col_next >= cfg.cols) begin
            col_in = '0;
            wc_in  = '0;
            co_in  = '0;
            if (row_next >= cfg.rows) begin
               row_in = '0;
               wr_in  = '0;
               ro_in  = '0;
            end else begin
               row_in = row_next[COORD_W-1:0];
               if (ro_end) begin
                  ro_in = '0;
                  wr_in = wr_ff + 8'd1;
               end else begin
                  ro_in = ro_ff + 3'd1;
               end
            end
         end else begin
            col_in = col_next[COORD_W-1:0];
            if (co_end) begin
               co_in = '0;
               wc_in = wc_ff + 8'd1;
            end else begin
               co_in = co_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         wr_ff  <= '0;
         wc_ff  <= '0;
         ro_ff  <= '0;
         co_ff  <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         wr_ff  <= wr_in;
         wc_ff  <= wc_in;
         ro_ff  <= ro_in;
         co_ff  <= co_in;
      end
   end

   always_comb begin
      pos.row       = row_ff;
      pos.col       = col_ff;
      pos.wr        = wr_ff;
      pos.wc        = wc_ff;
      pos.in_window = ({1'b0, row_ff} < cfg.row_lim) && ({1'b0, col_ff} < cfg.col_lim);
      pos.first     = (ro_ff == '0) && (co_ff == '0);
      pos.emit      = pos.in_window && ro_end && co_end;
      pos.map_last  = ({1'b0, wr_ff} == cfg.pr_m1) && ({1'b0, wc_ff} == cfg.pc_m1);
   end

endmodule

/* sv/mpa_best.sv */
// Running-maximum store, compare-and-update stage and result register.
module mpa_best (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  mpa_pkg::pos_type            pos,
   input  logic [mpa_pkg::VALUE_W-1:0] value,
   input  logic [mpa_pkg::DIM_W-1:0]   pc,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output mpa_pkg::result_type         rsp,
   output logic                        can_load
);
   import mpa_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   pos_type            s1_pos_ff;
   logic [VALUE_W-1:0] s1_value_ff;
   logic               fwd_valid_ff, fwd_valid_in;
   entry_type          fwd_ff;
   entry_type          ram_rdata, stored, updated;
   logic               take, s1_move, rsp_free;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff;
   logic [16:0]        idx_full;

   mpa_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_MAP_COLS)
   ) u_ram (
      .clock(clock),
      .we   (s1_move && s1_pos_ff.in_window),
      .waddr(s1_pos_ff.wc),
      .wdata(updated),
      .re   (load),
      .raddr(pos.wc),
      .rdata(ram_rdata)
   );

   assign stored = fwd_valid_ff ? fwd_ff : ram_rdata;
   assign take   = s1_pos_ff.first
                || ($signed(s1_value_ff) > $signed(stored.value))
                || ((s1_value_ff == stored.value) && (s1_pos_ff.col < stored.col));

   always_comb begin
      updated = stored;
      if (take) begin
         updated.value = s1_value_ff;
         updated.row   = s1_pos_ff.row;
         updated.col   = s1_pos_ff.col;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign s1_move  = s1_valid_ff && (!s1_pos_ff.emit || rsp_free);
   assign can_load = !s1_valid_ff || s1_move;
   assign idx_full = 17'(s1_pos_ff.wr) * 17'(pc) + 17'(s1_pos_ff.wc);

   always_comb begin
      s1_valid_in  = load ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      fwd_valid_in = fwd_valid_ff;
      if (load) begin
         // write in flight at this edge is missed by the read: bypass it
         fwd_valid_in = s1_move && s1_pos_ff.in_window && (s1_pos_ff.wc == pos.wc);
      end
      if (s1_move && s1_pos_ff.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_pos_ff   <= pos;
         s1_value_ff <= value;
         fwd_ff      <= updated;
      end
      if (s1_move && s1_pos_ff.emit) begin
         rsp_ff.value <= updated.value;
         rsp_ff.row   <= updated.row;
         rsp_ff.col   <= updated.col;
         rsp_ff.idx   <= idx_full[IDX_W-1:0];
         rsp_ff.last  <= s1_pos_ff.map_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* sv/max_pool_with_argmax.sv */
// Top level of the 2-D max pooling block with argmax.
//
// Pixels enter on the req_ stream, one per request, in raster order over a
// map_rows by map_cols map. Every pool_height by pool_width window yields one
// request on the rsp_ stream when its bottom-right pixel arrives: the maximum,
// its absolute row and column, the row-major pooled index, and tlast on the
// final pooled cell of the map. Pixels outside whole windows give nothing.
//
// Throughput: one pixel per clock while req_tready is high. A result passes
// from the accept edge of the pixel that closes its window through the
// compare-and-update stage, which loads the result register. The per-column
// maximum store is a RAM read at the accept edge, ahead of its update; a
// bypass covers back-to-back pixels of the same window column.
//
// Reset clears the position to row 0, column 0, loads the register defaults
// and drops any pending result. After reset, and after every csr_ write,
// req_tready stays low while the settle timer runs down and window geometry
// and position offsets are rebuilt. When the receiver holds rsp_tready low,
// the result register holds; pixels keep entering until the next
// window-closing pixel reaches the update stage, then req_tready falls.
module max_pool_with_argmax (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_we,
   input  logic [1:0]                     csr_addr,
   input  logic [mpa_pkg::CSR_DATA_W-1:0] csr_wdata,
   // pixel requests
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mpa_pkg::REQ_DATA_W-1:0] req_tdata,  // [15:0] pixel_value
   // pooled results
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [15:0] max_value, [23:16] max_row, [31:24] max_col, [47:32] pooled_index
   output logic [mpa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast   // last_of_map
);
   import mpa_pkg::*;

   cfg_type    cfg;
   pos_type    pos;
   result_type rsp;
   logic       settled, can_load, accept;

   mpa_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata),
      .cfg      (cfg),
      .settled  (settled)
   );

   // hold off pixels until geometry is settled and the update stage can move
   assign req_tready = settled && can_load;
   assign accept     = req_tvalid && req_tready;

   mpa_pos u_pos (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .recalc (!settled),
      .advance(accept),
      .pos    (pos)
   );

   mpa_best u_best (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .pos      (pos),
      .value    (req_tdata[VALUE_W-1:0]),
      .pc       (cfg.pc),
      .rsp_ready(rsp_tready),
      .rsp_valid(rsp_tvalid),
      .rsp      (rsp),
      .can_load (can_load)
   );

   assign rsp_tdata = {rsp.idx, rsp.col, rsp.row, rsp.value};
   assign rsp_tlast = rsp.last;

endmodule

/* sv/mpa_checker.sv */
// Port-level assertions for the max pooling block, bound to the top level.
module mpa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           csr_we,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mpa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);

   // reset drops any pending result
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // geometry rebuild blocks pixels after a configuration write
   assert property (@(posedge clock) disable iff (reset) csr_we |=> !req_tready)
      else $error("pixel accepted right after configuration write");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("stalled result dropped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind max_pool_with_argmax mpa_checker u_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for the max pooling block with argmax.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mpa_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 120;

   // One pooled window as it leaves the block.
   typedef struct packed {
      logic [IDX_W-1:0]   index;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [VALUE_W-1:0] value;
      logic               last;
   } pooled_cell_type;

   // How the result side decides to take a request.
   typedef enum {SINK_READY, SINK_COIN, SINK_RARE, SINK_PATTERN} sink_mode_type;

   // Running-max predictor plus the queue of pooled cells still owed by the block.
   class pool_scoreboard;
      logic [POOL_W-1:0]         pool_h, pool_w;
      logic [DIM_W-1:0]          rows_reg, cols_reg;
      logic signed [VALUE_W-1:0] best_value [MAX_MAP_COLS];
      logic [COORD_W-1:0]        best_row [MAX_MAP_COLS];
      logic [COORD_W-1:0]        best_col [MAX_MAP_COLS];
      logic [COORD_W-1:0]        pos_row, pos_col;
      pooled_cell_type           expected_cells [$];
      int                        pixels_seen, results_checked, faults;

      function new();
         pool_h = 4'd2;
         pool_w = 4'd2;
         rows_reg = 9'd256;
         cols_reg = 9'd256;
         pos_row = '0;
         pos_col = '0;
         foreach (best_value[i]) begin
            best_value[i] = '0;
            best_row[i] = '0;
            best_col[i] = '0;
         end
         pixels_seen = 0;
         results_checked = 0;
         faults = 0;
      endfunction

      function int clamp_range(int v, int lo, int hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function void write_reg(csr_index_type index, logic [DIM_W-1:0] v);
         case (index)
            CSR_POOL_HEIGHT: pool_h = v[POOL_W-1:0];
            CSR_POOL_WIDTH:  pool_w = v[POOL_W-1:0];
            CSR_MAP_ROWS:    rows_reg = v;
            CSR_MAP_COLS:    cols_reg = v;
            default: ;
         endcase
      endfunction

      function int map_pixels();
         return clamp_range(rows_reg, 1, 256) * clamp_range(cols_reg, 1, MAX_MAP_COLS);
      endfunction

      // Fold one accepted pixel into the window store; queue a cell when a window closes.
      function void note_pixel(logic [VALUE_W-1:0] raw);
         int ph, pw, nr, nc, pr, pc, r, c, wc, ro, co, idx;
         logic signed [VALUE_W-1:0] v;
         pooled_cell_type owed;
         v = raw;
         ph = clamp_range(pool_h, 1, 8);
         pw = clamp_range(pool_w, 1, 8);
         nr = clamp_range(rows_reg, 1, 256);
         nc = clamp_range(cols_reg, 1, MAX_MAP_COLS);
         pr = nr / ph;
         pc = nc / pw;
         r = pos_row;
         c = pos_col;
         pixels_seen++;
         if (r < pr * ph && c < pc * pw) begin
            wc = c / pw;
            ro = r % ph;
            co = c % pw;
            // equal values move the argmax only toward a smaller column
            if ((ro == 0 && co == 0) || v > best_value[wc] ||
                (v == best_value[wc] && c < int'(best_col[wc]))) begin
               best_value[wc] = v;
               best_row[wc] = r[COORD_W-1:0];
               best_col[wc] = c[COORD_W-1:0];
            end
            if (ro == ph - 1 && co == pw - 1) begin
               idx = (r / ph) * pc + wc;
               owed.value = best_value[wc];
               owed.row = best_row[wc];
               owed.col = best_col[wc];
               owed.index = idx[IDX_W-1:0];
               owed.last = (idx == pr * pc - 1);
               expected_cells = {expected_cells, owed};
            end
         end
         c++;
         if (c >= nc) begin
            c = 0;
            r++;
            if (r >= nr) r = 0;
         end
         pos_row = r[COORD_W-1:0];
         pos_col = c[COORD_W-1:0];
      endfunction

      function void check_cell(logic [RSP_DATA_W-1:0] data, logic last);
         pooled_cell_type seen, want;
         seen = {data[47:32], data[31:24], data[23:16], data[15:0], last};
         results_checked++;
         if (expected_cells.size() == 0) begin
            faults++;
            $display("%0t: result with nothing pending: value %0d row %0d col %0d index %0d",
                     $time, $signed(seen.value), seen.row, seen.col, seen.index);
            return;
         end
         want = expected_cells.pop_front();
         if (seen !== want) begin
            faults++;
            $display("%0t: expected value %0d row %0d col %0d index %0d last %0b",
                     $time, $signed(want.value), want.row, want.col, want.index, want.last);
            $display("%0t:   actual value %0d row %0d col %0d index %0d last %0b",
                     $time, $signed(seen.value), seen.row, seen.col, seen.index, seen.last);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [1:0]            csr_addr = CSR_POOL_HEIGHT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   pool_scoreboard board;
   logic           hold_request = 1'b0;
   int             hold_left = 0;
   int             quiet_cycles = 0;
   int             phase = 0;

   max_pool_with_argmax dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] pixel_value
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [15:0] max_value, [23:16] max_row, [31:24] max_col,
                                 // [47:32] pooled_index
      .rsp_tlast  (rsp_tlast)    // last_of_map
   );

   always #1 clock = ~clock;

   // Result side: take a long hold-off when asked, else stall on a mode picked at random.
   sink_mode_type sink_mode = SINK_READY;
   int            sink_left = 0;
   logic [7:0]    stall_pattern = 8'hFF;

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_request <= 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (sink_left == 0) begin
            sink_mode = sink_mode_type'($urandom_range(0, 3));
            sink_left = $urandom_range(20, 120);
            stall_pattern = 8'($urandom) | 8'h01;
         end
         sink_left--;
         case (sink_mode)
            SINK_READY: rsp_tready <= 1'b1;
            SINK_COIN:  rsp_tready <= 1'($urandom_range(0, 1));
            SINK_RARE:  rsp_tready <= ($urandom_range(0, 7) == 0);
            default: begin
               rsp_tready <= stall_pattern[0];
               stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            end
         endcase
      end
   end

   // Check every result request against the oldest pending cell.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_cell(rsp_tdata, rsp_tlast);
   end

   // Abort when neither side has moved a request for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, nothing moved for %0d cycles, %0d cells pending",
                     $time, quiet_cycles, board.expected_cells.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Offer one pixel from a falling edge on; return at the falling edge after its accept.
   task automatic send_pixel(input logic [REQ_DATA_W-1:0] v);
      req_tvalid <= 1'b1;
      req_tdata <= v;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_pixel(v);
      @(negedge clock);
   endtask

   function automatic logic [REQ_DATA_W-1:0] pixel_stimulus();
      logic [REQ_DATA_W-1:0] corner [6];
      corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001};
      case ($urandom_range(0, 5))
         0: return corner[$urandom_range(0, 5)];
         1: return 16'($urandom_range(0, 6)) - 16'd3;   // near-equal values for ties
         default: return 16'($urandom);
      endcase
   endfunction

   // Stream random pixels in bursts; at pause_at, hold off until every cell has come.
   task automatic feed_pixels(input int count, input int pause_at);
      int burst, gap;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) begin
            req_tvalid <= 1'b0;
            while (board.expected_cells.size() != 0) @(posedge clock);
            @(negedge clock);
            burst = $urandom_range(1, 24);
         end else if (burst == 0) begin
            burst = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         send_pixel(pixel_stimulus());
         burst--;
      end
      req_tvalid <= 1'b0;
   endtask

   // Wait out pending cells and the pipeline before touching the registers.
   task automatic settle_block();
      while (board.expected_cells.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic apply_geometry(input logic [DIM_W-1:0] ph, input logic [DIM_W-1:0] pw,
                                 input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
      logic [DIM_W-1:0] values [4];
      values = '{ph, pw, rows, cols};
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_addr <= csr_index_type'(i);
         csr_wdata <= values[i];
         board.write_reg(csr_index_type'(i), values[i]);
      end
      @(negedge clock);
      csr_we <= 1'b0;
      phase++;
   endtask

   function automatic logic [DIM_W-1:0] random_pool();
      case ($urandom_range(0, 9))
         0: return '0;                                // saturates to 1
         1: return DIM_W'($urandom_range(9, 15));     // saturates to 8
         2: return DIM_W'(8);
         default: return DIM_W'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] random_dim();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return DIM_W'(1);
         default: return DIM_W'($urandom_range(2, 12));
      endcase
   endfunction

   initial begin
      logic [REQ_DATA_W-1:0] ties [12];
      board = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Ties and value extremes over three 2x2 windows: equal values in the lower
      // row move the argmax left only, an all-minimum window, a repeated maximum.
      ties = '{16'd100, 16'd200, 16'h8000, 16'h8000, 16'h0000, 16'h7FFF,
               16'd200, 16'hFFFB, 16'h8000, 16'h8000, 16'hFFFF, 16'h7FFF};
      apply_geometry(9'd2, 9'd2, 9'd2, 9'd6);
      foreach (ties[i]) send_pixel(ties[i]);
      req_tvalid <= 1'b0;
      settle_block();

      // Partial column on a 3x5 map; stop mid-map, then shrink the map so the
      // position lies outside it and must wrap, then a window bigger than the map.
      apply_geometry(9'd2, 9'd2, 9'd3, 9'd5);
      feed_pixels(7, -1);
      settle_block();
      apply_geometry(9'd2, 9'd2, 9'd1, 9'd2);
      feed_pixels(3, -1);
      settle_block();

      // Random geometries over whole maps, with a few fixed settings mixed in.
      while (phase < 9 || board.pixels_seen < 400) begin
         case (phase)
            3: begin
               // every pixel is a window: stall the result side hard, then drain
               // mid-map; two maps back to back
               apply_geometry(9'd1, 9'd1, 9'd4, 9'd8);
               hold_request <= 1'b1;
               feed_pixels(2 * board.map_pixels(), 30);
            end
            4: begin
               // tall narrow map, saturated pool height
               apply_geometry(9'd15, 9'd1, 9'd24, 9'd1);
               feed_pixels(board.map_pixels(), -1);
            end
            6: begin
               // widest map from saturated columns, pool height written as zero
               apply_geometry(9'd0, 9'd8, 9'd1, 9'h1FF);
               feed_pixels(board.map_pixels(), -1);
            end
            default: begin
               apply_geometry(random_pool(), random_pool(), random_dim(), random_dim());
               feed_pixels(board.map_pixels(), -1);
            end
         endcase
         settle_block();
      end

      repeat (10) @(posedge clock);
      if (board.expected_cells.size() != 0) board.faults++;
      $display("Covered %0d pixels over %0d geometry settings, pools 1 to 8, maps 1 to 256,",
               board.pixels_seen, phase);
      $display("saturated register values; %0d pooled cells compared, %0d failures",
               board.results_checked, board.faults);
      if (board.faults == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
